[rtl/bsgr_pkg.sv]
// Shared types, register indexes and constants of the bit share group recombiner.
`timescale 1ns / 1ps

package bsgr_pkg;

    // Fixed block dimensions
    localparam int NUM_MODULI     = 4;
    localparam int MAX_COMPONENTS = 4;
    localparam int MODULUS_BITS   = 32;
    localparam int SHARE_W        = 64;
    localparam int RESIDUE_W      = 32;
    localparam int CFG_DATA_W     = 33;
    localparam int CFG_INDEX_W    = 3;
    localparam int COUNT_W        = 3;
    localparam int DIV_STEPS      = SHARE_W;

    // Highest component count that the block honors
    localparam int COMP_CAP = (MAX_COMPONENTS < NUM_MODULI) ? MAX_COMPONENTS : NUM_MODULI;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_COMPONENT_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MODULUS_A       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MODULUS_B       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MODULUS_C       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MODULUS_D       = 3'd4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // latch share magnitude and sign, restart remainder
        logic skip;      // step over a component that takes no bits
        logic div_step;  // one restoring remainder step
        logic fix;       // fold a negative share into 0..q-1
        logic dbl_step;  // one modular doubling
        logic acc_add;   // add into accumulator and advance the bit position
        logic emit;      // load the result word and clear the group
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic comp_over; // current component is past the last one in use
        logic q_triv;    // current component has modulus one
        logic div_done;  // last remainder step is under way
        logic dbl_done;  // doubling count has reached the bit position
    } t_dp_status;

endpackage

[rtl/bsgr_ctrl.sv]
// Sequencing state machine of the bit share group recombiner.
`timescale 1ns / 1ps

module bsgr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_share_valid,
    output logic                o_share_stall,
    output logic                o_res_valid,
    input  logic                i_res_stall,
    input  bsgr_pkg::t_dp_status i_status,
    output bsgr_pkg::t_dp_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRE  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_FIX  = 3'd3;
    localparam logic [2:0] S_DBL  = 3'd4;
    localparam logic [2:0] S_ADD  = 3'd5;
    localparam logic [2:0] S_POST = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    assign o_share_stall = (r_state != S_IDLE);
    assign o_res_valid   = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_res_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_share_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PRE;
                end
            end
            S_PRE: begin
                if (i_status.comp_over) begin
                    n_state = S_EMIT;
                end else if (i_status.q_triv) begin
                    o_cmd.skip = 1'b1;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_DBL;
            end
            S_DBL: begin
                if (i_status.dbl_done) begin
                    n_state = S_ADD;
                end else begin
                    o_cmd.dbl_step = 1'b1;
                end
            end
            S_ADD: begin
                o_cmd.acc_add = 1'b1;
                n_state       = S_POST;
            end
            S_POST: begin
                if (i_status.comp_over) begin
                    n_state = S_EMIT;
                end else if (i_status.q_triv) begin
                    o_cmd.skip = 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                // wait for the output register to free up
                if (!r_out_valid || !i_res_stall) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result raised outside the emit state");

    a_accept_starts_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_share_valid && !o_share_stall) |=> (r_state == S_PRE))
        else $error("accepted word did not start an item");

    a_div_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_status.div_done) |=> (r_state == S_DIV))
        else $error("remainder loop left early");

endmodule

[rtl/bsgr_datapath.sv]
// Registers, remainder unit, accumulators and result register of the recombiner.
`timescale 1ns / 1ps

module bsgr_datapath #(
    parameter int P_MODULUS_BITS = bsgr_pkg::MODULUS_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [bsgr_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [bsgr_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic signed [bsgr_pkg::SHARE_W-1:0]   i_share_value,
    input  bsgr_pkg::t_dp_cmd                     i_cmd,
    output bsgr_pkg::t_dp_status                  o_status,
    output logic [bsgr_pkg::RESIDUE_W-1:0]        o_residue_a,
    output logic [bsgr_pkg::RESIDUE_W-1:0]        o_residue_b,
    output logic [bsgr_pkg::RESIDUE_W-1:0]        o_residue_c,
    output logic [bsgr_pkg::RESIDUE_W-1:0]        o_residue_d
);

    // Width of an effective modulus, and so of a residue
    localparam int QW = (P_MODULUS_BITS < bsgr_pkg::CFG_DATA_W) ?
                        P_MODULUS_BITS + 1 : bsgr_pkg::CFG_DATA_W;
    localparam int BW = $clog2(QW + 1);
    localparam int IW = $clog2(bsgr_pkg::DIV_STEPS);
    localparam int NM = bsgr_pkg::NUM_MODULI;
    localparam int CW = bsgr_pkg::COUNT_W;
    localparam int SW = bsgr_pkg::SHARE_W;
    localparam int RW = bsgr_pkg::RESIDUE_W;

    logic [CW-1:0]                   r_count, n_count;
    logic [bsgr_pkg::CFG_DATA_W-1:0] r_mod [NM];
    logic [bsgr_pkg::CFG_DATA_W-1:0] n_mod [NM];
    logic [QW-1:0]                   r_acc [NM];
    logic [QW-1:0]                   n_acc [NM];
    logic [RW-1:0]                   r_res [NM];
    logic [RW-1:0]                   n_res [NM];
    logic [CW-1:0]                   r_comp, n_comp;
    logic [BW-1:0]                   r_bit, n_bit;
    logic [SW-1:0]                   r_u, n_u;
    logic                            r_neg, n_neg;
    logic [QW-1:0]                   r_rem, n_rem;
    logic [IW-1:0]                   r_iter, n_iter;

    logic [CW-1:0] lim;
    logic [63:0]   q64;
    logic [63:0]   top64;
    logic [QW-1:0] q_cur;
    logic [QW-1:0] q_m1;
    logic [QW-1:0] acc_cur;
    logic [BW-1:0] bit_inc;
    logic          comp_last;
    logic          cfg_hit;
    logic [QW:0]   rem2;
    logic [QW:0]   sum2;
    logic [63:0]   acc_wide;

    assign o_cfg_ready = 1'b1;
    assign cfg_hit     = i_cfg_valid && (i_cfg_index <= bsgr_pkg::REG_MODULUS_D);

    // Number of components in use
    always_comb begin
        lim = (r_count == '0) ? CW'(1) : r_count;
        if (lim > CW'(bsgr_pkg::COMP_CAP)) begin
            lim = CW'(bsgr_pkg::COMP_CAP);
        end
    end

    // Effective modulus of the current component
    always_comb begin
        top64 = 64'(1) << P_MODULUS_BITS;
        q64   = 64'(r_mod[r_comp[1:0]]);
        if (q64 == 64'd0) begin
            q64 = 64'd1;
        end
        if (q64 > top64) begin
            q64 = top64;
        end
        q_cur = q64[QW-1:0];
    end

    assign q_m1      = q_cur - QW'(1);
    assign acc_cur   = r_acc[r_comp[1:0]];
    assign bit_inc   = r_bit + BW'(1);
    assign comp_last = ((q_m1 >> bit_inc) == '0);

    assign o_status.comp_over = (r_comp >= lim);
    assign o_status.q_triv    = (q_cur == QW'(1));
    assign o_status.div_done  = (r_iter == IW'(bsgr_pkg::DIV_STEPS - 1));
    assign o_status.dbl_done  = (8'(r_iter) == 8'(r_bit));

    assign o_residue_a = r_res[0];
    assign o_residue_b = r_res[1];
    assign o_residue_c = r_res[2];
    assign o_residue_d = r_res[3];

    always_comb begin
        n_count  = r_count;
        n_mod    = r_mod;
        n_acc    = r_acc;
        n_res    = r_res;
        n_comp   = r_comp;
        n_bit    = r_bit;
        n_u      = r_u;
        n_neg    = r_neg;
        n_rem    = r_rem;
        n_iter   = r_iter;
        rem2     = '0;
        sum2     = '0;
        acc_wide = '0;

        // Latch the share as sign and magnitude
        if (i_cmd.load) begin
            n_neg  = i_share_value[SW-1];
            n_u    = i_share_value[SW-1] ? (SW'(0) - $unsigned(i_share_value))
                                         : $unsigned(i_share_value);
            n_rem  = '0;
            n_iter = '0;
        end

        if (i_cmd.skip) begin
            n_comp = r_comp + CW'(1);
        end

        // Shift in one dividend bit and restore
        if (i_cmd.div_step) begin
            rem2 = {r_rem, r_u[SW-1]};
            if (rem2 >= {1'b0, q_cur}) begin
                rem2 = rem2 - {1'b0, q_cur};
            end
            n_rem  = rem2[QW-1:0];
            n_u    = r_u << 1;
            n_iter = r_iter + IW'(1);
        end

        // Negate the remainder for a negative share
        if (i_cmd.fix) begin
            if (r_neg && r_rem != '0) begin
                n_rem = q_cur - r_rem;
            end
            n_iter = '0;
        end

        // Weight by two, once per bit position
        if (i_cmd.dbl_step) begin
            rem2 = {r_rem, 1'b0};
            if (rem2 >= {1'b0, q_cur}) begin
                rem2 = rem2 - {1'b0, q_cur};
            end
            n_rem  = rem2[QW-1:0];
            n_iter = r_iter + IW'(1);
        end

        // Accumulate and advance the bit position
        if (i_cmd.acc_add) begin
            sum2 = {1'b0, r_rem} + {1'b0, acc_cur};
            if (sum2 >= {1'b0, q_cur}) begin
                sum2 = sum2 - {1'b0, q_cur};
            end
            n_acc[r_comp[1:0]] = sum2[QW-1:0];
            if (comp_last) begin
                n_bit  = '0;
                n_comp = r_comp + CW'(1);
            end else begin
                n_bit = bit_inc;
            end
        end

        // Load the result word and clear the group
        if (i_cmd.emit) begin
            for (int j = 0; j < NM; j++) begin
                acc_wide = 64'(r_acc[j]);
                n_res[j] = (CW'(j) < lim) ? acc_wide[RW-1:0] : '0;
                n_acc[j] = '0;
            end
            n_comp = '0;
            n_bit  = '0;
        end

        // Register write restarts the group
        if (cfg_hit) begin
            if (i_cfg_index == bsgr_pkg::REG_COMPONENT_COUNT) begin
                n_count = i_cfg_data[CW-1:0];
            end else begin
                n_mod[2'(i_cfg_index - bsgr_pkg::REG_MODULUS_A)] = i_cfg_data;
            end
            for (int j = 0; j < NM; j++) begin
                n_acc[j] = '0;
            end
            n_comp = '0;
            n_bit  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CW'(1);
            for (int j = 0; j < NM; j++) begin
                r_mod[j] <= bsgr_pkg::CFG_DATA_W'(2);
                r_acc[j] <= '0;
            end
            r_comp <= '0;
            r_bit  <= '0;
            r_iter <= '0;
        end else begin
            r_count <= n_count;
            r_mod   <= n_mod;
            r_acc   <= n_acc;
            r_comp  <= n_comp;
            r_bit   <= n_bit;
            r_iter  <= n_iter;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_u   <= n_u;
        r_neg <= n_neg;
        r_rem <= n_rem;
    end

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_comp == '0 && r_bit == '0 && r_acc[0] == '0))
        else $error("group not cleared after emit");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> (r_comp == '0 && r_bit == '0 && r_acc[NM-1] == '0))
        else $error("group not restarted by register write");

    a_comp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_comp <= CW'(NM))
        else $error("component index ran past the moduli");

endmodule

[rtl/bit_share_group_recombiner_core.sv]
// Top level of the bit share group recombiner: controller and datapath.
//
//   channel   direction  handshake                 payload
//   share     in         i_share_valid/o_share_stall i_share_value (64, signed)
//   result    out        o_res_valid/i_res_stall     o_residue_a..o_residue_d (32 each)
//   config    in         i_cfg_valid/o_cfg_ready     i_cfg_index (3), i_cfg_data (33)
//
// A share word is worked in steps, b its bit position in its component: one
// restoring remainder step per dividend bit, then b modular doublings, then the
// add. Each component of modulus one is stepped over on the way, and the word
// that completes a group also loads the result register.
// Reset is synchronous, active low; registers return to count 1 and moduli of 2.
// A result waits in its register while stalled; the next share word is taken meanwhile.
`timescale 1ns / 1ps

module bit_share_group_recombiner_core #(
    parameter int P_MODULUS_BITS = bsgr_pkg::MODULUS_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bsgr_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [bsgr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_share_valid,
    output logic                                o_share_stall,
    input  logic signed [bsgr_pkg::SHARE_W-1:0] i_share_value,
    output logic                                o_res_valid,
    input  logic                                i_res_stall,
    output logic [bsgr_pkg::RESIDUE_W-1:0]      o_residue_a,
    output logic [bsgr_pkg::RESIDUE_W-1:0]      o_residue_b,
    output logic [bsgr_pkg::RESIDUE_W-1:0]      o_residue_c,
    output logic [bsgr_pkg::RESIDUE_W-1:0]      o_residue_d
);

    bsgr_pkg::t_dp_cmd    dp_cmd;
    bsgr_pkg::t_dp_status dp_status;

    // Sequencer
    bsgr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_share_valid (i_share_valid),
        .o_share_stall (o_share_stall),
        .o_res_valid   (o_res_valid),
        .i_res_stall   (i_res_stall),
        .i_status      (dp_status),
        .o_cmd         (dp_cmd)
    );

    // Arithmetic and storage
    bsgr_datapath #(
        .P_MODULUS_BITS (P_MODULUS_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_share_value (i_share_value),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .o_residue_a   (o_residue_a),
        .o_residue_b   (o_residue_b),
        .o_residue_c   (o_residue_c),
        .o_residue_d   (o_residue_d)
    );

endmodule
